>>> hw/rtl/linear_float_to_srgb8_top_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the linear float to srgb8 encoder
// ----------------------------------------------------------------------------
`ifndef LINEAR_FLOAT_TO_SRGB8_TOP_ASSERT_SVH
`define LINEAR_FLOAT_TO_SRGB8_TOP_ASSERT_SVH

// same-cycle implication
`define L2S_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define L2S_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// implication after a fixed delay
`define L2S_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/l2s_pkg.sv
// ----------------------------------------------------------------------------
// l2s_pkg
// shared types, register codes and decision threshold tables
// ----------------------------------------------------------------------------
`default_nettype none

package l2s_pkg;

    // fixed point domain for the gained sample: 48 fraction bits
    localparam int C_FIX_W = 48;
    // request to result latency in cycles
    localparam int C_LAT   = 12;

    localparam logic [31:0] C_GAIN_RST = 32'h3F80_0000;

    typedef logic [C_FIX_W-1:0] t_fix;
    typedef t_fix t_thr_tab [256];

    typedef enum logic [1:0] {
        CFG_GAIN = 2'd0,
        CFG_LIN  = 2'd1
    } t_cfg_idx;

    // item travelling down the search pipeline
    typedef struct packed {
        logic       vld;
        logic       lin;
        logic       done;
        logic [7:0] code;
        t_fix       fix;
    } t_srch;

    // smallest fixed point value that reaches code k
    function automatic t_fix f_thresh(int k, bit lin);
        real t;
        real x;
        t = (real'(k) - 0.5) / 255.0;
        if (lin) begin
            if (t <= 12.92 * 0.0031308) begin
                x = t / 12.92;
            end else begin
                x = $pow((t + 0.055) / 1.055, 2.4);
            end
        end else begin
            x = t;
        end
        return t_fix'(longint'($ceil(x * 281474976710656.0)));
    endfunction

    function automatic t_thr_tab f_build(bit lin);
        t_thr_tab tab;
        tab[0] = '0;
        for (int k = 1; k < 256; k++) begin
            tab[k] = f_thresh(k, lin);
        end
        return tab;
    endfunction

    localparam t_thr_tab C_THR_LIN = f_build(1'b1);
    localparam t_thr_tab C_THR_DIR = f_build(1'b0);

endpackage

`default_nettype wire

>>> hw/rtl/l2s_front.sv
// ----------------------------------------------------------------------------
// l2s_front
// float multiply by the gain, special cases, conversion to fixed point
// ----------------------------------------------------------------------------
`default_nettype none

module l2s_front import l2s_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire logic [31:0] i_sample,
    input  wire logic [31:0] i_gain,
    input  wire logic        i_lin,
    output t_srch            o_srch
);

    `include "linear_float_to_srgb8_top_assert.svh"

    // stage 1: decode and mantissa product
    logic        r1_vld, r1_lin, r1_done;
    logic [7:0]  r1_code;
    logic [47:0] r1_prod;
    logic [8:0]  r1_esum;

    logic        n1_done;
    logic [7:0]  n1_code;
    logic [23:0] w_ma, w_mb;
    logic [8:0]  w_ea, w_eb;
    logic        w_nan, w_zero, w_neg, w_inf;

    always_comb begin
        w_ma   = {(i_sample[30:23] != 8'd0), i_sample[22:0]};
        w_mb   = {(i_gain[30:23] != 8'd0), i_gain[22:0]};
        w_ea   = (i_sample[30:23] == 8'd0) ? 9'd1 : {1'b0, i_sample[30:23]};
        w_eb   = (i_gain[30:23] == 8'd0) ? 9'd1 : {1'b0, i_gain[30:23]};
        w_nan  = ((i_sample[30:23] == 8'hFF) && (i_sample[22:0] != 23'd0))
              || ((i_gain[30:23] == 8'hFF) && (i_gain[22:0] != 23'd0));
        w_zero = (i_sample[30:0] == 31'd0) || (i_gain[30:0] == 31'd0);
        w_neg  = i_sample[31] ^ i_gain[31];
        w_inf  = (i_sample[30:23] == 8'hFF) || (i_gain[30:23] == 8'hFF);
        n1_done = w_nan || w_zero || w_neg || w_inf;
        n1_code = (!w_nan && !w_zero && !w_neg && w_inf) ? 8'd255 : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        r1_lin  <= i_lin;
        r1_done <= n1_done;
        r1_code <= n1_code;
        r1_prod <= w_ma * w_mb;
        r1_esum <= w_ea + w_eb;
    end

    // stage 2: leading zero count of the product
    logic        r2_vld, r2_lin, r2_done;
    logic [7:0]  r2_code;
    logic [47:0] r2_prod;
    logic [8:0]  r2_esum;
    logic [5:0]  r2_lz;
    logic [5:0]  n2_lz;

    always_comb begin
        n2_lz = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (r1_prod[i]) begin
                n2_lz = 6'(47 - i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_lin  <= r1_lin;
        r2_done <= r1_done;
        r2_code <= r1_code;
        r2_prod <= r1_prod;
        r2_esum <= r1_esum;
        r2_lz   <= n2_lz;
    end

    // stage 3: normalize and round to nearest even
    logic               r3_vld, r3_lin, r3_done;
    logic [7:0]         r3_code;
    logic [23:0]        r3_man;
    logic signed [10:0] r3_exp;

    logic [47:0]        w_norm;
    logic               w_rnd;
    logic [24:0]        w_sum;
    logic signed [10:0] w_exp;
    logic [23:0]        n3_man;
    logic signed [10:0] n3_exp;

    always_comb begin
        w_norm = r2_prod << r2_lz;
        w_exp  = $signed({2'b00, r2_esum}) - 11'sd253 - $signed({5'd0, r2_lz});
        w_rnd  = w_norm[23] && ((w_norm[22:0] != 23'd0) || w_norm[24]);
        w_sum  = {1'b0, w_norm[47:24]} + {24'd0, w_rnd};
        if (w_sum[24]) begin
            n3_man = w_sum[24:1];
            n3_exp = w_exp + 11'sd1;
        end else begin
            n3_man = w_sum[23:0];
            n3_exp = w_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_lin  <= r2_lin;
        r3_done <= r2_done;
        r3_code <= r2_code;
        r3_man  <= n3_man;
        r3_exp  <= n3_exp;
    end

    // stage 4: range checks and placement into the fixed point word
    t_srch              r4_srch;
    t_srch              n4_srch;
    logic signed [10:0] w_sh;

    always_comb begin
        w_sh          = r3_exp + 11'sd25;
        n4_srch.vld   = r3_vld;
        n4_srch.lin   = r3_lin;
        n4_srch.done  = r3_done;
        n4_srch.code  = r3_code;
        n4_srch.fix   = t_fix'(r3_man) << w_sh[4:0];
        if (!r3_done) begin
            if (r3_exp >= 11'sd0) begin
                n4_srch.done = 1'b1;
                n4_srch.code = 8'd255;
            end else if (r3_exp < -11'sd24) begin
                n4_srch.done = 1'b1;
                n4_srch.code = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_srch <= '0;
        end else begin
            r4_srch <= n4_srch;
        end
    end

    assign o_srch = r4_srch;

    `L2S_ASSERT_IMP(a_norm_lead, i_clk, i_rst_n, r3_vld && !r3_done, r3_man[23], "mantissa not normalized")

endmodule

`default_nettype wire

>>> hw/rtl/l2s_search.sv
// ----------------------------------------------------------------------------
// l2s_search
// one step of the binary search over the decision thresholds
// ----------------------------------------------------------------------------
`default_nettype none

module l2s_search import l2s_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [2:0] i_bit,
    input  t_srch           i_srch,
    output t_srch           o_srch
);

    `include "linear_float_to_srgb8_top_assert.svh"

    t_srch      r_srch;
    t_srch      n_srch;
    logic [7:0] w_cand;
    t_fix       w_thr;

    always_comb begin
        w_cand = i_srch.code | (8'd1 << i_bit);
        w_thr  = i_srch.lin ? C_THR_LIN[w_cand] : C_THR_DIR[w_cand];
        n_srch = i_srch;
        if (!i_srch.done && (i_srch.fix >= w_thr)) begin
            n_srch.code = w_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_srch <= '0;
        end else begin
            r_srch <= n_srch;
        end
    end

    assign o_srch = r_srch;

    `L2S_ASSERT_NXT(a_one_bit, i_clk, i_rst_n, i_srch.vld, $countones(r_srch.code ^ $past(i_srch.code)) <= 1, "search step changed more than one code bit")

endmodule

`default_nettype wire

>>> hw/rtl/linear_float_to_srgb8_top.sv
// ----------------------------------------------------------------------------
// linear_float_to_srgb8_top
// float32 linear sample to 8-bit srgb code, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   request channel: drive i_sample_bits with a float32 pattern and raise
//   start; the request is taken at any rising edge with start high and busy
//   low. busy stays low, so a request can be taken in every cycle.
//   result channel: o_valid strobes for one cycle with o_code; the receiver
//   must take it then, there is no back pressure.
//   config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and
//   i_cfg_data. index 0 is the float32 exposure gain, index 1 the linear
//   mode bit, other indexes are dropped. write only while no request is in
//   flight.
// timing
//   a request passes four front stages (multiply, leading zero count, round,
//   fixed point placement) then eight binary search steps over the 255
//   decision thresholds, one code bit per stage. throughput is one request
//   per cycle.
// reset
//   synchronous active low; clears all pipeline valids, gain goes to 1.0 and
//   linear mode on. requests in flight at reset are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_float_to_srgb8_top import l2s_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] i_sample_bits,
    // result channel
    output logic             o_valid,
    output logic [7:0]       o_code,
    // configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    `include "linear_float_to_srgb8_top_assert.svh"

    // configuration registers
    logic [31:0] r_gain;
    logic        r_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= C_GAIN_RST;
            r_lin  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN: begin
                    r_gain <= i_cfg_data;
                end
                CFG_LIN: begin
                    r_lin <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline never stalls
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // front end: multiply, special cases, fixed point
    t_srch w_srch [9];

    l2s_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (start && !busy),
        .i_sample (i_sample_bits),
        .i_gain   (r_gain),
        .i_lin    (r_lin),
        .o_srch   (w_srch[0])
    );

    // eight search steps, msb first
    for (genvar g = 0; g < 8; g++) begin : g_search
        l2s_search u_search (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bit   (3'(7 - g)),
            .i_srch  (w_srch[g]),
            .o_srch  (w_srch[g+1])
        );
    end

    assign o_valid = w_srch[8].vld;
    assign o_code  = w_srch[8].code;

    // every request gives a strobe after the fixed latency
    `L2S_ASSERT_DLY(a_req_to_res, i_clk, i_rst_n, start && !busy, C_LAT, o_valid, "result strobe missing")
    // no strobe without a request
    `L2S_ASSERT_IMP(a_res_from_req, i_clk, i_rst_n, o_valid, $past(start && !busy, C_LAT), "result strobe without request")

endmodule

`default_nettype wire
